// ----- rtl/core/rwe_pkg.sv -----
// Shared types and constants for the Rice encoder with escape code.
package rwe_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned ShiftW   = 4;
  localparam int unsigned CodeW    = 25;
  localparam int unsigned LenW     = 5;
  localparam int unsigned PendW    = 31;
  localparam int unsigned WordW    = 32;
  localparam int unsigned GiveUp   = 8;
  localparam logic [ShiftW-1:0] ShiftReset = 4'd3;

  typedef struct packed {
    logic [CodeW-1:0] bits;
    logic [LenW-1:0]  len;
  } code_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic             full;
    logic             full_last;
    logic [WordW-1:0] full_word;
    logic             flush;
    logic [WordW-1:0] flush_word;
  } words_t;

endpackage

// ----- rtl/core/rwe_code.sv -----
// Rice code generator: turns one sample into a right-aligned code and its length.
module rwe_code (
  input  logic [rwe_pkg::SampleW-1:0] sample_i,
  input  logic [rwe_pkg::ShiftW-1:0]  shift_i,
  output rwe_pkg::code_t              code_o
);

  logic        neg;
  logic [16:0] mag;
  logic [16:0] quo;
  logic [16:0] rem;
  logic        esc;
  logic [rwe_pkg::CodeW-1:0] rice_bits;

  always_comb begin
    neg = sample_i[15];
    mag = neg ? (17'd0 - {1'b1, sample_i}) : {1'b0, sample_i};
    quo = mag >> shift_i;
    esc = (quo >= 17'(rwe_pkg::GiveUp));
    rem = mag & ((17'd1 << shift_i) - 17'd1);
    rice_bits = (25'd1 << ({1'b0, shift_i} + 5'd1))
              | ({24'd0, neg} << shift_i)
              | {8'd0, rem};
    if (esc) begin
      code_o.bits = {8'd0, 1'b1, sample_i ^ 16'h8000};
      code_o.len  = 5'd25;
    end else begin
      code_o.bits = rice_bits;
      code_o.len  = {2'd0, quo[2:0]} + 5'd2 + {1'b0, shift_i};
    end
  end

endmodule

// ----- rtl/core/rwe_pack.sv -----
// Bit accumulator: merges codes into pending bits and forms full and flush words.
module rwe_pack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  rwe_pkg::code_t code_i,
  input  logic           last_i,
  output rwe_pkg::words_t words_o
);

  logic [rwe_pkg::PendW-1:0] pend_q, pend_d;
  logic [4:0]                cnt_q, cnt_d;
  logic [55:0]               acc;
  logic [5:0]                total;
  logic [4:0]                rem;
  logic [rwe_pkg::PendW-1:0] new_pend;
  logic [4:0]                new_cnt;

  always_comb begin
    acc      = ({25'd0, pend_q} << code_i.len) | {31'd0, code_i.bits};
    total    = {1'b0, cnt_q} + {1'b0, code_i.len};
    rem      = total[4:0];
    words_o.full      = total[5];
    words_o.full_word = 32'(acc >> rem);
    if (total[5]) begin
      new_pend = 31'(acc & ((56'd1 << rem) - 56'd1));
      new_cnt  = rem;
    end else begin
      new_pend = acc[30:0];
      new_cnt  = total[4:0];
    end
    words_o.full_last  = last_i && (new_cnt == 5'd0);
    words_o.flush      = last_i && (new_cnt != 5'd0);
    words_o.flush_word = {1'b0, new_pend} << (5'd0 - new_cnt);
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (fire_i) begin
      pend_d = last_i ? '0 : new_pend;
      cnt_d  = last_i ? '0 : new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/rice_encoder_with_escape_top.sv -----
// Rice encoder with escape code: code register, bit accumulator and output word queue.
// A sample's code is registered, then its words are registered in the output queue.
// Throughput: one sample per cycle; output drains one word per cycle while tready
// is high; the three-entry queue stalls the code register if it cannot take two words.
// Reset: asynchronous, active low; clears pending bits, queue and sets rice_shift to 3.
module rice_encoder_with_escape_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i,     // rice_shift
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample
  input  logic        s_axis_tlast,   // last_sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // packed_word
  output logic        m_axis_tlast    // last_word
);

  logic [rwe_pkg::ShiftW-1:0] shift_q;
  logic                       a_vld_q;
  rwe_pkg::code_t             a_code_q;
  logic                       a_last_q;
  rwe_pkg::code_t             code;
  rwe_pkg::words_t            words;
  rwe_pkg::entry_t            ent_q [3];
  rwe_pkg::entry_t            ent_d [3];
  rwe_pkg::entry_t            sh    [3];
  rwe_pkg::entry_t            first;
  rwe_pkg::entry_t            second;
  logic [1:0]                 cnt_q, cnt_d, cnt_pop, npush;
  logic                       pop, fire, s_acc;

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = ent_q[0].word;
  assign m_axis_tlast  = ent_q[0].last;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign cnt_pop       = cnt_q - {1'b0, pop};
  assign fire          = a_vld_q && (cnt_pop <= 2'd1);
  assign s_axis_tready = !a_vld_q || fire;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  rwe_code u_code (
    .sample_i (s_axis_tdata),
    .shift_i  (shift_q),
    .code_o   (code)
  );

  rwe_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .code_i  (a_code_q),
    .last_i  (a_last_q),
    .words_o (words)
  );

  always_comb begin
    sh[0] = pop ? ent_q[1] : ent_q[0];
    sh[1] = pop ? ent_q[2] : ent_q[1];
    sh[2] = ent_q[2];
    first.word  = words.full ? words.full_word : words.flush_word;
    first.last  = words.full ? words.full_last : 1'b1;
    second.word = words.flush_word;
    second.last = 1'b1;
    npush = fire ? ({1'b0, words.full} + {1'b0, words.flush}) : 2'd0;
    for (int i = 0; i < 3; i++) begin
      ent_d[i] = sh[i];
      if ((2'(i) == cnt_pop) && (npush != 2'd0)) begin
        ent_d[i] = first;
      end else if ((2'(i) == cnt_pop + 2'd1) && (npush == 2'd2)) begin
        ent_d[i] = second;
      end
    end
    cnt_d = cnt_pop + npush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= rwe_pkg::ShiftReset;
      a_vld_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        shift_q <= cfg_data_i;
      end
      if (s_acc) begin
        a_vld_q <= 1'b1;
      end else if (fire) begin
        a_vld_q <= 1'b0;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      a_code_q <= code;
      a_last_q <= s_axis_tlast;
    end
    for (int i = 0; i < 3; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

endmodule
